// ===== design/dibl_pkg.sv =====
// Shared types and constants for the display idle blank and lock timer.
package dibl_pkg;

    localparam int MASK_W       = 8;
    localparam int DT_W         = 16;
    localparam int CNT_W        = 32;
    localparam int TIME_CFG_W   = 27;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int LOOKAHEAD_MS = 5000;
    localparam int POLL_MS      = 1000;
    localparam int POLL_W       = $clog2(POLL_MS + 1);

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_ACTIVITY,
        KIND_CONSUME,
        KIND_SET
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLANK_AFTER,
        REG_LOCK_AFTER,
        REG_LOCK_ENABLED,
        REG_AUDIO_PRESENCE,
        REG_HAS_SESSION
    } reg_index_t;

    typedef struct packed {
        logic [TIME_CFG_W-1:0] blank_after_ms;
        logic [TIME_CFG_W-1:0] lock_after_ms;
        logic                  lock_enabled;
        logic                  audio_presence;
        logic                  has_session;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [DT_W-1:0]   dt_ms;
        logic              inhibited;
        logic              session_locked;
        logic              audio_running;
        logic [MASK_W-1:0] outputs_enabled;
        logic [MASK_W-1:0] commit_ok;
        logic [IDX_W-1:0]  output_index;
        logic              blanked_value;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] dark_mask;
        logic              screens_dark;
        logic              wake_flag;
        logic              lock_request;
        logic [MASK_W-1:0] commit_mask;
        logic              commit_lights_on;
        logic [MASK_W-1:0] refused_mask;
        logic [MASK_W-1:0] frame_request_mask;
        logic              audio_hold;
    } result_t;

endpackage

// ===== design/dibl_cfg.sv =====
// Configuration register bank of the idle timer.
module dibl_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [dibl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dibl_pkg::TIME_CFG_W-1:0]    cfg_data,
    output dibl_pkg::cfg_t                     cfg
);

    dibl_pkg::cfg_t cfg_reg;
    dibl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (dibl_pkg::reg_index_t'(cfg_index))
                dibl_pkg::REG_BLANK_AFTER:    cfg_next.blank_after_ms = cfg_data;
                dibl_pkg::REG_LOCK_AFTER:     cfg_next.lock_after_ms  = cfg_data;
                dibl_pkg::REG_LOCK_ENABLED:   cfg_next.lock_enabled   = cfg_data[0];
                dibl_pkg::REG_AUDIO_PRESENCE: cfg_next.audio_presence = cfg_data[0];
                dibl_pkg::REG_HAS_SESSION:    cfg_next.has_session    = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blank_after_ms <= dibl_pkg::TIME_CFG_W'(600000);
            cfg_reg.lock_after_ms  <= '0;
            cfg_reg.lock_enabled   <= 1'b0;
            cfg_reg.audio_presence <= 1'b1;
            cfg_reg.has_session    <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/dibl_core.sv =====
// Idle state registers and the single-pass step logic for one word.
module dibl_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  dibl_pkg::item_t    item,
    input  dibl_pkg::cfg_t     cfg,
    output dibl_pkg::result_t  res
);

    logic [dibl_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [dibl_pkg::MASK_W-1:0] dark_reg, dark_next;
    logic [dibl_pkg::MASK_W-1:0] refused_reg, refused_next;
    logic                        lock_fired_reg, lock_fired_next;
    logic                        wake_reg, wake_next;
    logic                        sound_reg, sound_next;
    logic [dibl_pkg::POLL_W-1:0] poll_reg, poll_next;

    logic                        any_dark;
    logic [dibl_pkg::CNT_W:0]    ahead;
    logic [dibl_pkg::CNT_W:0]    sum;
    logic [dibl_pkg::CNT_W-1:0]  count_sat;
    logic                        blank_on;
    logic                        lock_armed;
    logic                        pending;
    logic                        poll_gt;
    logic                        hold;
    logic [dibl_pkg::MASK_W-1:0] cand;
    logic [dibl_pkg::MASK_W-1:0] commits;
    logic [dibl_pkg::MASK_W-1:0] frames;
    logic                        lights_on;
    logic                        wflag;
    logic                        lreq;

    assign any_dark   = |dark_reg;
    assign blank_on   = cfg.blank_after_ms != '0;
    assign lock_armed = (cfg.lock_after_ms != '0) && cfg.lock_enabled && !lock_fired_reg;
    assign ahead      = {1'b0, count_reg} + (dibl_pkg::CNT_W+1)'(dibl_pkg::LOOKAHEAD_MS);
    assign pending    = (blank_on && !any_dark
                         && ahead >= (dibl_pkg::CNT_W+1)'(cfg.blank_after_ms))
                     || (lock_armed && ahead >= (dibl_pkg::CNT_W+1)'(cfg.lock_after_ms));
    assign sum        = {1'b0, count_reg} + (dibl_pkg::CNT_W+1)'(item.dt_ms);
    assign count_sat  = sum[dibl_pkg::CNT_W] ? '1 : sum[dibl_pkg::CNT_W-1:0];
    assign poll_gt    = dibl_pkg::DT_W'(poll_reg) > item.dt_ms;
    assign cand       = item.outputs_enabled & ~dark_reg & ~refused_reg;

    always_comb
    begin
        count_next      = count_reg;
        dark_next       = dark_reg;
        refused_next    = refused_reg;
        lock_fired_next = lock_fired_reg;
        wake_next       = wake_reg;
        sound_next      = sound_reg;
        poll_next       = poll_reg;
        hold            = 1'b0;
        commits         = '0;
        frames          = '0;
        lights_on       = 1'b0;
        wflag           = 1'b0;
        lreq            = 1'b0;

        case (item.kind)
            dibl_pkg::KIND_TICK:
            begin
                wake_next = 1'b0;
                if (!item.inhibited)
                begin
                    if (!cfg.audio_presence || item.session_locked || !pending)
                    begin
                        sound_next = 1'b0;
                        poll_next  = '0;
                    end
                    else if (poll_gt)
                    begin
                        poll_next = dibl_pkg::POLL_W'(dibl_pkg::DT_W'(poll_reg) - item.dt_ms);
                        hold      = sound_reg;
                    end
                    else
                    begin
                        poll_next  = dibl_pkg::POLL_W'(dibl_pkg::POLL_MS);
                        sound_next = item.audio_running;
                        hold       = item.audio_running || sound_reg;
                    end

                    if (hold)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_sat;
                        // darken: a refused commit marks the output failed and leaves it lit
                        if (blank_on && !any_dark && cfg.has_session
                            && count_sat >= dibl_pkg::CNT_W'(cfg.blank_after_ms))
                        begin
                            commits      = cand;
                            dark_next    = dark_reg | (cand & item.commit_ok);
                            refused_next = (refused_reg & ~(cand & item.commit_ok))
                                         | (cand & ~item.commit_ok);
                        end
                        // blanking switched off: light everything held dark
                        if (!blank_on && any_dark && cfg.has_session)
                        begin
                            commits      = dark_reg;
                            frames       = dark_reg;
                            lights_on    = 1'b1;
                            dark_next    = '0;
                            refused_next = refused_reg & ~(dark_reg & item.commit_ok);
                        end
                        if (lock_armed && !item.session_locked
                            && count_sat >= dibl_pkg::CNT_W'(cfg.lock_after_ms))
                        begin
                            lock_fired_next = 1'b1;
                            lreq            = 1'b1;
                        end
                    end
                end
            end
            dibl_pkg::KIND_ACTIVITY:
            begin
                count_next      = '0;
                refused_next    = '0;
                lock_fired_next = 1'b0;
                if (any_dark)
                begin
                    wake_next = 1'b1;
                    if (cfg.has_session)
                    begin
                        commits   = dark_reg;
                        frames    = dark_reg;
                        lights_on = 1'b1;
                        dark_next = '0;
                    end
                end
            end
            dibl_pkg::KIND_CONSUME:
            begin
                wflag     = wake_reg;
                wake_next = 1'b0;
            end
            dibl_pkg::KIND_SET:
            begin
                dark_next[item.output_index] = item.blanked_value;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            dark_reg       <= '0;
            refused_reg    <= '0;
            lock_fired_reg <= 1'b0;
            wake_reg       <= 1'b0;
            sound_reg      <= 1'b0;
            poll_reg       <= '0;
        end
        else if (step_en)
        begin
            count_reg      <= count_next;
            dark_reg       <= dark_next;
            refused_reg    <= refused_next;
            lock_fired_reg <= lock_fired_next;
            wake_reg       <= wake_next;
            sound_reg      <= sound_next;
            poll_reg       <= poll_next;
        end
    end

    always_comb
    begin
        res.dark_mask          = dark_next;
        res.screens_dark       = |dark_next;
        res.wake_flag          = wflag;
        res.lock_request       = lreq;
        res.commit_mask        = commits;
        res.commit_lights_on   = lights_on;
        res.refused_mask       = refused_next;
        res.frame_request_mask = frames;
        res.audio_hold         = hold;
    end

    a_lock_once: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.lock_request |=> lock_fired_reg && !res.lock_request)
        else $error("lock request fired twice in one idle stretch");

    a_activity_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.kind == dibl_pkg::KIND_ACTIVITY |=> refused_reg == '0 && count_reg == '0)
        else $error("activity left failure marks or idle count");

    a_frames_committed: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> (res.frame_request_mask & ~res.commit_mask) == '0)
        else $error("redraw requested for an output without a commit");

    a_tick_clears_wake: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.kind == dibl_pkg::KIND_TICK |=> !wake_reg)
        else $error("wake mark survived a tick");

    a_hold_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.audio_hold |=> count_reg == '0)
        else $error("audio hold did not reset the idle count");

endmodule

// ===== design/display_idle_blank_lock_timer_top.sv =====
// Top level of the display idle blank and lock timer: handshakes and pipeline registers.
// Accepted words are held in s1_item_reg; results are registered in out_res_reg.
// Throughput: one word per cycle unless out_ready stalls; each step is one core pass.
// Input and result registers hold two words under a stall; in_ready then drops.
// Configuration writes are always accepted (cfg_ready is always high).
// Reset (rst_n low, asynchronous) clears the idle state and loads register defaults.
module display_idle_blank_lock_timer_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dibl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dibl_pkg::TIME_CFG_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         kind,
    input  logic [dibl_pkg::DT_W-1:0]          dt_ms,
    input  logic                               inhibited,
    input  logic                               session_locked,
    input  logic                               audio_running,
    input  logic [dibl_pkg::MASK_W-1:0]        outputs_enabled,
    input  logic [dibl_pkg::MASK_W-1:0]        commit_ok,
    input  logic [dibl_pkg::IDX_W-1:0]         output_index,
    input  logic                               blanked_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dibl_pkg::MASK_W-1:0]        dark_mask,
    output logic                               screens_dark,
    output logic                               wake_flag,
    output logic                               lock_request,
    output logic [dibl_pkg::MASK_W-1:0]        commit_mask,
    output logic                               commit_lights_on,
    output logic [dibl_pkg::MASK_W-1:0]        refused_mask,
    output logic [dibl_pkg::MASK_W-1:0]        frame_request_mask,
    output logic                               audio_hold
);

    dibl_pkg::cfg_t    cfg;
    dibl_pkg::item_t   in_item;
    dibl_pkg::item_t   s1_item_reg;
    logic              s1_valid_reg;
    dibl_pkg::result_t res;
    dibl_pkg::result_t out_res_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              step_en;

    assign cfg_ready = 1'b1;

    dibl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        in_item.kind            = dibl_pkg::kind_t'(kind);
        in_item.dt_ms           = dt_ms;
        in_item.inhibited       = inhibited;
        in_item.session_locked  = session_locked;
        in_item.audio_running   = audio_running;
        in_item.outputs_enabled = outputs_enabled;
        in_item.commit_ok       = commit_ok;
        in_item.output_index    = output_index;
        in_item.blanked_value   = blanked_value;
    end

    // advance the staged word whenever the result register is free or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign step_en  = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (step_en)
        begin
            out_res_reg <= res;
        end
    end

    dibl_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign out_valid          = out_valid_reg;
    assign dark_mask          = out_res_reg.dark_mask;
    assign screens_dark       = out_res_reg.screens_dark;
    assign wake_flag          = out_res_reg.wake_flag;
    assign lock_request       = out_res_reg.lock_request;
    assign commit_mask        = out_res_reg.commit_mask;
    assign commit_lights_on   = out_res_reg.commit_lights_on;
    assign refused_mask       = out_res_reg.refused_mask;
    assign frame_request_mask = out_res_reg.frame_request_mask;
    assign audio_hold         = out_res_reg.audio_hold;

endmodule

// ===== sim/display_idle_blank_lock_timer_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the display idle blank and lock timer top level.
module display_idle_blank_lock_timer_top_tb;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int LATENCY         = 2;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int BLOCKS          = 8;
    localparam int BLOCK_WORDS     = 60;
    localparam logic [dibl_pkg::TIME_CFG_W-1:0] DAY_MS = 27'd86400000;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [dibl_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [dibl_pkg::TIME_CFG_W-1:0]   cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [1:0]                        kind;
    logic [dibl_pkg::DT_W-1:0]         dt_ms;
    logic                              inhibited;
    logic                              session_locked;
    logic                              audio_running;
    logic [dibl_pkg::MASK_W-1:0]       outputs_enabled;
    logic [dibl_pkg::MASK_W-1:0]       commit_ok;
    logic [dibl_pkg::IDX_W-1:0]        output_index;
    logic                              blanked_value;
    logic                              out_valid;
    logic                              out_ready;
    logic [dibl_pkg::MASK_W-1:0]       dark_mask;
    logic                              screens_dark;
    logic                              wake_flag;
    logic                              lock_request;
    logic [dibl_pkg::MASK_W-1:0]       commit_mask;
    logic                              commit_lights_on;
    logic [dibl_pkg::MASK_W-1:0]       refused_mask;
    logic [dibl_pkg::MASK_W-1:0]       frame_request_mask;
    logic                              audio_hold;

    display_idle_blank_lock_timer_top u_top (.*);

    always #HALF_PERIOD clk = ~clk;

    // Timer model: settings and idle state
    logic [dibl_pkg::TIME_CFG_W-1:0]   blank_ms;
    logic [dibl_pkg::TIME_CFG_W-1:0]   lock_ms;
    logic                              lock_on;
    logic                              audio_on;
    logic                              session_on;
    logic [dibl_pkg::CNT_W-1:0]        idle_ms;
    logic [dibl_pkg::MASK_W-1:0]       dark_q;
    logic [dibl_pkg::MASK_W-1:0]       refused_q;
    logic                              lock_done;
    logic                              wake_q;
    logic                              sound_q;
    logic [dibl_pkg::CNT_W-1:0]        poll_ms;

    dibl_pkg::result_t                 due_q[$];

    typedef struct {
        bit                              is_cfg;
        logic [dibl_pkg::CFG_IDX_W-1:0]  cfg_sel;
        logic [dibl_pkg::TIME_CFG_W-1:0] cfg_val;
        dibl_pkg::item_t                 stim;
        bit                              typed;
        dibl_pkg::result_t               want;
    } row_t;

    row_t                    dir_rows[$];

    int                      send_idle_pct;
    int                      recv_idle_pct;
    logic                    stall_req;
    int                      errors;
    int                      words_in;
    int                      results_seen;
    int                      reg_writes;
    int                      holds_seen;
    int                      locks_seen;
    int                      blanks_seen;
    int                      relights_seen;
    int                      quiet_cycles;

    task automatic flag_error(string what);
        errors++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [dibl_pkg::MASK_W-1:0] got,
                               logic [dibl_pkg::MASK_W-1:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic void drive_power(logic darken, logic [dibl_pkg::MASK_W-1:0] en,
                                        logic [dibl_pkg::MASK_W-1:0] ok,
                                        inout logic [dibl_pkg::MASK_W-1:0] commits,
                                        inout logic [dibl_pkg::MASK_W-1:0] frames,
                                        inout logic lights);
        if (!session_on)
            return;
        for (int i = 0; i < dibl_pkg::MASK_W; i++)
        begin
            if (darken)
            begin
                if (en[i] && !dark_q[i] && !refused_q[i])
                begin
                    commits[i] = 1'b1;
                    lights     = 1'b0;
                    // a refusal leaves the output lit and out of this stretch
                    if (ok[i])
                    begin
                        dark_q[i]    = 1'b1;
                        refused_q[i] = 1'b0;
                    end
                    else
                        refused_q[i] = 1'b1;
                end
            end
            else if (dark_q[i])
            begin
                // lit again even when the commit is refused
                commits[i] = 1'b1;
                lights     = 1'b1;
                dark_q[i]  = 1'b0;
                if (ok[i])
                    refused_q[i] = 1'b0;
                frames[i]  = 1'b1;
            end
        end
    endfunction

    function automatic dibl_pkg::result_t step_timer(dibl_pkg::item_t s);
        dibl_pkg::result_t           r;
        logic [dibl_pkg::CNT_W:0]    ahead;
        logic [dibl_pkg::CNT_W:0]    sum;
        logic                        pending;
        logic                        was;
        logic                        hold;
        logic [dibl_pkg::MASK_W-1:0] commits;
        logic [dibl_pkg::MASK_W-1:0] frames;
        logic                        lights;
        r       = '0;
        hold    = 1'b0;
        commits = '0;
        frames  = '0;
        lights  = 1'b0;
        case (s.kind)
            dibl_pkg::KIND_TICK:
            begin
                wake_q = 1'b0;
                if (!s.inhibited)
                begin
                    ahead   = {1'b0, idle_ms}
                            + (dibl_pkg::CNT_W+1)'(dibl_pkg::LOOKAHEAD_MS);
                    pending = (blank_ms != 0 && dark_q == 0 && ahead >= blank_ms) ||
                              (lock_ms != 0 && lock_on && !lock_done && ahead >= lock_ms);
                    if (!audio_on || s.session_locked || !pending)
                    begin
                        sound_q = 1'b0;
                        poll_ms = '0;
                    end
                    else if (poll_ms > s.dt_ms)
                    begin
                        poll_ms = poll_ms - s.dt_ms;
                        hold    = sound_q;
                    end
                    else
                    begin
                        // poll due: resample, but a sound heard last poll still holds
                        was     = sound_q;
                        poll_ms = dibl_pkg::CNT_W'(dibl_pkg::POLL_MS);
                        sound_q = s.audio_running;
                        hold    = sound_q || was;
                    end
                    if (hold)
                        idle_ms = '0;
                    else
                    begin
                        sum     = {1'b0, idle_ms} + (dibl_pkg::CNT_W+1)'(s.dt_ms);
                        idle_ms = sum[dibl_pkg::CNT_W] ? '1 : sum[dibl_pkg::CNT_W-1:0];
                        if (blank_ms != 0 && dark_q == 0 && idle_ms >= blank_ms)
                            drive_power(1'b1, s.outputs_enabled, s.commit_ok,
                                        commits, frames, lights);
                        if (blank_ms == 0 && dark_q != 0)
                            drive_power(1'b0, s.outputs_enabled, s.commit_ok,
                                        commits, frames, lights);
                        if (lock_ms != 0 && lock_on && !lock_done && !s.session_locked &&
                            idle_ms >= lock_ms)
                        begin
                            lock_done      = 1'b1;
                            r.lock_request = 1'b1;
                        end
                    end
                end
            end
            dibl_pkg::KIND_ACTIVITY:
            begin
                idle_ms   = '0;
                refused_q = '0;
                lock_done = 1'b0;
                if (dark_q != 0)
                begin
                    drive_power(1'b0, s.outputs_enabled, s.commit_ok, commits, frames, lights);
                    wake_q = 1'b1;
                end
            end
            dibl_pkg::KIND_CONSUME:
            begin
                r.wake_flag = wake_q;
                wake_q      = 1'b0;
            end
            default:
                dark_q[s.output_index] = s.blanked_value;
        endcase
        r.dark_mask          = dark_q;
        r.screens_dark       = |dark_q;
        r.commit_mask        = commits;
        r.commit_lights_on   = lights;
        r.refused_mask       = refused_q;
        r.frame_request_mask = frames;
        r.audio_hold         = hold;
        return r;
    endfunction

    function automatic dibl_pkg::result_t quiet_result(logic [dibl_pkg::MASK_W-1:0] dm,
                                                       logic sd);
        dibl_pkg::result_t r;
        r              = '0;
        r.dark_mask    = dm;
        r.screens_dark = sd;
        return r;
    endfunction

    function automatic logic [dibl_pkg::TIME_CFG_W-1:0] pick_span();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DAY_MS;
            2:       return dibl_pkg::TIME_CFG_W'($urandom_range(1, 86400000));
            default: return dibl_pkg::TIME_CFG_W'($urandom_range(1, 8000));
        endcase
    endfunction

    function automatic logic [dibl_pkg::TIME_CFG_W-1:0] flag_word(logic b);
        logic [dibl_pkg::TIME_CFG_W-1:0] w;
        w    = dibl_pkg::TIME_CFG_W'($urandom);
        w[0] = b;
        return w;
    endfunction

    task automatic add_step(dibl_pkg::kind_t k, logic [dibl_pkg::DT_W-1:0] dt,
                            logic inh, logic lk, logic run,
                            logic [dibl_pkg::MASK_W-1:0] en, logic [dibl_pkg::MASK_W-1:0] ok,
                            logic [dibl_pkg::IDX_W-1:0] idx, logic bv,
                            bit typed = 1'b0, dibl_pkg::result_t want = '0);
        row_t r;
        r                     = '{default: '0};
        r.stim.kind           = k;
        r.stim.dt_ms          = dt;
        r.stim.inhibited      = inh;
        r.stim.session_locked = lk;
        r.stim.audio_running  = run;
        r.stim.outputs_enabled = en;
        r.stim.commit_ok      = ok;
        r.stim.output_index   = idx;
        r.stim.blanked_value  = bv;
        r.typed               = typed;
        r.want                = want;
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(logic [dibl_pkg::CFG_IDX_W-1:0] sel,
                           logic [dibl_pkg::TIME_CFG_W-1:0] val);
        row_t r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.cfg_sel = sel;
        r.cfg_val = val;
        dir_rows.push_back(r);
    endtask

    task automatic write_reg(logic [dibl_pkg::CFG_IDX_W-1:0] sel,
                             logic [dibl_pkg::TIME_CFG_W-1:0] val, bit last);
        cfg_index <= sel;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        case (sel)
            dibl_pkg::REG_BLANK_AFTER:    blank_ms   = val;
            dibl_pkg::REG_LOCK_AFTER:     lock_ms    = val;
            dibl_pkg::REG_LOCK_ENABLED:   lock_on    = val[0];
            dibl_pkg::REG_AUDIO_PRESENCE: audio_on   = val[0];
            dibl_pkg::REG_HAS_SESSION:    session_on = val[0];
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic send_word(dibl_pkg::item_t s, bit typed, dibl_pkg::result_t want);
        dibl_pkg::result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        kind            <= s.kind;
        dt_ms           <= s.dt_ms;
        inhibited       <= s.inhibited;
        session_locked  <= s.session_locked;
        audio_running   <= s.audio_running;
        outputs_enabled <= s.outputs_enabled;
        commit_ok       <= s.commit_ok;
        output_index    <= s.output_index;
        blanked_value   <= s.blanked_value;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        r = step_timer(s);
        words_in++;
        if (r.audio_hold)
            holds_seen++;
        if (r.lock_request)
            locks_seen++;
        if (r.commit_mask != 0)
        begin
            if (r.commit_lights_on)
                relights_seen++;
            else
                blanks_seen++;
        end
        due_q.push_back(typed ? want : r);
    endtask

    // Settle the block before touching its registers
    task automatic drain_results();
        in_valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        dibl_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_q.size() == 0)
                flag_error("result word with no expectation waiting");
            else
            begin
                want = due_q.pop_front();
                results_seen++;
                check_field("dark_mask", dark_mask, want.dark_mask);
                check_field("screens_dark", screens_dark, want.screens_dark);
                check_field("wake_flag", wake_flag, want.wake_flag);
                check_field("lock_request", lock_request, want.lock_request);
                check_field("commit_mask", commit_mask, want.commit_mask);
                check_field("commit_lights_on", commit_lights_on, want.commit_lights_on);
                check_field("refused_mask", refused_mask, want.refused_mask);
                check_field("frame_request_mask", frame_request_mask,
                            want.frame_request_mask);
                check_field("audio_hold", audio_hold, want.audio_hold);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("display_idle_blank_lock_timer_top_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin : drain_side
        bit stall_taken;
        stall_taken = 1'b0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_req && !stall_taken)
            begin
                // hold off long enough for the block to back up into its input
                stall_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        dibl_pkg::item_t s;
        int              pick;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        kind            = '0;
        dt_ms           = '0;
        inhibited       = 1'b0;
        session_locked  = 1'b0;
        audio_running   = 1'b0;
        outputs_enabled = '0;
        commit_ok       = '0;
        output_index    = '0;
        blanked_value   = 1'b0;
        stall_req       = 1'b0;
        blank_ms        = 27'd600000;
        lock_ms         = '0;
        lock_on         = 1'b0;
        audio_on        = 1'b1;
        session_on      = 1'b1;
        idle_ms         = '0;
        dark_q          = '0;
        refused_q       = '0;
        lock_done       = 1'b0;
        wake_q          = 1'b0;
        sound_q         = 1'b0;
        poll_ms         = '0;
        send_idle_pct   = 37;
        recv_idle_pct   = 47;

        // Fresh from reset: nothing dark, nothing pending; then output 7 is set dark
        add_step(dibl_pkg::KIND_CONSUME, 16'd0, 0, 0, 0, 8'h00, 8'h00, 3'd0, 0, 1,
                 quiet_result(8'h00, 0));
        add_step(dibl_pkg::KIND_TICK, 16'd0, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0, 1,
                 quiet_result(8'h00, 0));
        add_step(dibl_pkg::KIND_SET, 16'd0, 0, 0, 0, 8'h00, 8'h00, 3'd7, 1, 1,
                 quiet_result(8'h80, 1));
        add_step(dibl_pkg::KIND_CONSUME, 16'd0, 0, 0, 0, 8'h00, 8'h00, 3'd0, 0, 1,
                 quiet_result(8'h80, 1));
        // wake with a refused relight, then swallow the wake
        add_step(dibl_pkg::KIND_ACTIVITY, 16'd0, 0, 0, 0, 8'hFF, 8'h7F, 3'd0, 0);
        add_step(dibl_pkg::KIND_CONSUME, 16'd0, 0, 0, 0, 8'h00, 8'h00, 3'd0, 0);
        add_cfg(dibl_pkg::REG_BLANK_AFTER, 27'd100);
        add_cfg(dibl_pkg::REG_LOCK_AFTER, 27'd150);
        add_cfg(dibl_pkg::REG_LOCK_ENABLED, 27'd1);
        add_cfg(dibl_pkg::REG_AUDIO_PRESENCE, 27'd0);
        // blank with half the commits refused, and fire the lock once
        add_step(dibl_pkg::KIND_TICK, 16'hFFFF, 0, 0, 0, 8'hFF, 8'h0F, 3'd0, 0);
        add_step(dibl_pkg::KIND_TICK, 16'hFFFF, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_ACTIVITY, 16'd0, 0, 0, 0, 8'h00, 8'h55, 3'd0, 0);
        add_step(dibl_pkg::KIND_SET, 16'd0, 0, 0, 0, 8'h00, 8'h00, 3'd0, 1);
        // blanking switched off lights the dark output again
        add_cfg(dibl_pkg::REG_BLANK_AFTER, 27'd0);
        add_step(dibl_pkg::KIND_TICK, 16'd1, 0, 0, 0, 8'hFF, 8'h00, 3'd0, 0);
        add_cfg(dibl_pkg::REG_BLANK_AFTER, 27'd5000);
        add_cfg(dibl_pkg::REG_LOCK_AFTER, 27'd0);
        add_cfg(dibl_pkg::REG_AUDIO_PRESENCE, 27'd1);
        // sound near the threshold: hold, remember between polls, then let go
        add_step(dibl_pkg::KIND_ACTIVITY, 16'd0, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_TICK, 16'd300, 0, 0, 1, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_TICK, 16'd300, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_TICK, 16'd900, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_TICK, 16'd100, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_TICK, 16'd100, 0, 1, 1, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_TICK, 16'd4900, 1, 0, 1, 8'hFF, 8'hFF, 3'd0, 0);
        // without a session nothing is committed, yet activity still marks a wake
        add_cfg(dibl_pkg::REG_HAS_SESSION, 27'd0);
        add_step(dibl_pkg::KIND_TICK, 16'd4900, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_SET, 16'd0, 0, 0, 0, 8'h00, 8'h00, 3'd5, 1);
        add_step(dibl_pkg::KIND_ACTIVITY, 16'd0, 0, 0, 0, 8'hFF, 8'hFF, 3'd0, 0);
        add_step(dibl_pkg::KIND_CONSUME, 16'd0, 0, 0, 0, 8'h00, 8'h00, 3'd0, 0);
        add_cfg(dibl_pkg::REG_HAS_SESSION, 27'd1);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                if (i == 0 || !dir_rows[i-1].is_cfg)
                    drain_results();
                write_reg(dir_rows[i].cfg_sel, dir_rows[i].cfg_val,
                          i + 1 == dir_rows.size() || !dir_rows[i+1].is_cfg);
            end
            else
                send_word(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 37 : 0;
            for (int blk = 0; blk < BLOCKS; blk++)
            begin
                drain_results();
                if ($urandom_range(3) == 0)
                    write_reg(dibl_pkg::CFG_IDX_W'(int'(dibl_pkg::REG_HAS_SESSION) + 1
                                                   + $urandom_range(2)),
                              dibl_pkg::TIME_CFG_W'($urandom), 1'b0);
                write_reg(dibl_pkg::REG_BLANK_AFTER, pick_span(), 1'b0);
                write_reg(dibl_pkg::REG_LOCK_AFTER, pick_span(), 1'b0);
                write_reg(dibl_pkg::REG_LOCK_ENABLED, flag_word($urandom_range(1)), 1'b0);
                write_reg(dibl_pkg::REG_AUDIO_PRESENCE, flag_word($urandom_range(3) != 0),
                          1'b0);
                write_reg(dibl_pkg::REG_HAS_SESSION, flag_word($urandom_range(4) != 0),
                          1'b1);
                if (ph == 2 && blk == 0)
                    stall_req = 1'b1;
                repeat (BLOCK_WORDS)
                begin
                    pick   = $urandom_range(99);
                    s.kind = (pick < 83) ? dibl_pkg::KIND_TICK :
                             (pick < 87) ? dibl_pkg::KIND_ACTIVITY :
                             (pick < 95) ? dibl_pkg::KIND_CONSUME : dibl_pkg::KIND_SET;
                    case ($urandom_range(19))
                        0:       s.dt_ms = '0;
                        1:       s.dt_ms = '1;
                        2, 3:    s.dt_ms = dibl_pkg::DT_W'($urandom);
                        default: s.dt_ms = dibl_pkg::DT_W'($urandom_range(1500));
                    endcase
                    s.inhibited       = ($urandom_range(9) == 0);
                    s.session_locked  = ($urandom_range(6) == 0);
                    s.audio_running   = $urandom_range(1);
                    s.outputs_enabled = ($urandom_range(3) == 0) ?
                                        dibl_pkg::MASK_W'($urandom) : '1;
                    s.commit_ok       = ($urandom_range(3) == 0) ?
                                        dibl_pkg::MASK_W'($urandom) : '1;
                    s.output_index    = dibl_pkg::IDX_W'($urandom);
                    s.blanked_value   = $urandom_range(1);
                    send_word(s, 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2)
            @(posedge clk);

        $display("covered %0d input words, %0d results checked, %0d register writes",
                 words_in, results_seen, reg_writes);
        $display("saw %0d audio holds, %0d lock requests, %0d blanking and %0d relight commits",
                 holds_seen, locks_seen, blanks_seen, relights_seen);
        if (errors == 0)
            $display("display_idle_blank_lock_timer_top_tb: done, clean");
        else
            $display("display_idle_blank_lock_timer_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dibl_pkg.sv
design/dibl_cfg.sv
design/dibl_core.sv
design/display_idle_blank_lock_timer_top.sv
sim/display_idle_blank_lock_timer_top_tb.sv
